### rtl/pdws_pkg.sv
// Shared types, codes and default parameters of the pulse delay/width splitter.
`default_nettype none

package pdws_pkg;

    localparam int SERDES_BITS_DEF       = 4;
    localparam int NUM_OUTPUTS_DEF       = 8;
    localparam int COARSE_DELAY_BITS_DEF = 24;
    localparam int COARSE_WIDTH_BITS_DEF = 24;

    localparam logic [31:0] OP_MODE  = 32'h0000_0000;
    localparam logic [31:0] OP_DELAY = 32'h4000_0000;
    localparam logic [31:0] OP_WIDTH = 32'h8000_0000;
    localparam logic [1:0]  MODE_PAT = 2'h2;

    typedef enum logic [1:0] {
        CMD_MODE  = 2'd0,
        CMD_DELAY = 2'd1,
        CMD_WIDTH = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        WORD_SEL  = 2'd0,
        WORD_DLY  = 2'd1,
        WORD_WID  = 2'd2,
        WORD_MODE = 2'd3
    } t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CALC,
        ST_SEL,
        ST_DLY,
        ST_WID,
        ST_MODE
    } t_state;

    typedef struct packed {
        logic  accept;
        logic  start;
        logic  calc;
        t_word word;
    } t_dp_ctl;

    typedef struct packed {
        logic item_ok;
        logic div_idle;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/pdws_div.sv
// Divider by a constant divisor through a registered reciprocal multiplication.
`default_nettype none

module pdws_div
    import pdws_pkg::*;
#(
    parameter int NUM_W   = 26,
    parameter int DIVISOR = SERDES_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [NUM_W-1:0]             i_num,
    output logic                              o_busy,
    output logic [NUM_W-1:0]                  o_quot,
    output logic [$clog2(DIVISOR)-1:0]        o_rem
);

    localparam int RemW = $clog2(DIVISOR);
    // The quotient is floor(n * RECIP / 2^SH), exact for every n below 2^NUM_W.
    localparam int SH   = NUM_W + RemW;
    localparam int PW   = SH + NUM_W;
    localparam logic [PW-1:0] RECIP =
        PW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [NUM_W-1:0] r_num;
    logic [PW-1:0]    r_prod;
    logic [NUM_W-1:0] r_quot;
    logic [RemW-1:0]  r_rem;
    logic [1:0]       r_stage;

    logic [NUM_W-1:0] quot;
    logic [NUM_W-1:0] back;
    logic [NUM_W-1:0] diff;

    always_comb begin
        quot = r_prod[SH +: NUM_W];
        back = quot * NUM_W'(DIVISOR);
        diff = r_num - back;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (i_start) begin
            r_stage <= 2'b01;
        end else begin
            r_stage <= {r_stage[0], 1'b0};
        end
    end

    // The start registers the numerator; the product is registered next, then the quotient and remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
        end
        if (r_stage[0]) begin
            r_prod <= PW'(r_num) * RECIP;
        end
        if (r_stage[1]) begin
            r_quot <= quot;
            r_rem  <= diff[RemW-1:0];
        end
    end

    assign o_busy = |r_stage;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### rtl/pdws_ctrl.sv
// Controller state machine: request intake, divide wait and the four-word output run.
`default_nettype none

module pdws_ctrl
    import pdws_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire logic     i_m_tready,
    output logic          o_m_tvalid,
    output t_dp_ctl       o_ctl,
    input  wire t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && i_stat.item_ok) begin
                    n_state = ST_DIV_START;
                end
            end
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (i_stat.div_idle) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: n_state = ST_SEL;
            ST_SEL: begin
                if (i_m_tready) begin
                    n_state = ST_DLY;
                end
            end
            ST_DLY: begin
                if (i_m_tready) begin
                    n_state = ST_WID;
                end
            end
            ST_WID: begin
                if (i_m_tready) begin
                    n_state = ST_MODE;
                end
            end
            ST_MODE: begin
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_m_tvalid   = 1'b0;
        o_ctl.accept = 1'b0;
        o_ctl.start  = 1'b0;
        o_ctl.calc   = 1'b0;
        o_ctl.word   = WORD_SEL;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_ctl.accept = i_s_tvalid;
            end
            ST_DIV_START: o_ctl.start = 1'b1;
            ST_DIV_WAIT:  ;
            ST_CALC:      o_ctl.calc = 1'b1;
            ST_SEL: begin
                o_m_tvalid = 1'b1;
                o_ctl.word = WORD_SEL;
            end
            ST_DLY: begin
                o_m_tvalid = 1'b1;
                o_ctl.word = WORD_DLY;
            end
            ST_WID: begin
                o_m_tvalid = 1'b1;
                o_ctl.word = WORD_WID;
            end
            ST_MODE: begin
                o_m_tvalid = 1'b1;
                o_ctl.word = WORD_MODE;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/pdws_dp.sv
// Datapath: request check, per-output stores, coarse/fine split and output words.
`default_nettype none

module pdws_dp
    import pdws_pkg::*;
#(
    parameter int SERDES_BITS       = SERDES_BITS_DEF,
    parameter int NUM_OUTPUTS       = NUM_OUTPUTS_DEF,
    parameter int COARSE_DELAY_BITS = COARSE_DELAY_BITS_DEF,
    parameter int COARSE_WIDTH_BITS = COARSE_WIDTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [71:0] i_s_tdata,
    input  wire t_dp_ctl     i_ctl,
    output t_dp_stat         o_stat,
    output logic [31:0]      o_m_tdata,
    output logic             o_m_tuser,
    output logic             o_m_tlast
);

    localparam int SerW  = $clog2(SERDES_BITS);
    localparam int DlyW  = (COARSE_DELAY_BITS + SerW > 31) ? 31 : COARSE_DELAY_BITS + SerW;
    localparam int WidW  = (COARSE_WIDTH_BITS + SerW > 31) ? 31 : COARSE_WIDTH_BITS + SerW;
    localparam int IdxW  = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
    localparam logic [63:0] DlyLimit = 64'(SERDES_BITS) << COARSE_DELAY_BITS;
    localparam logic [63:0] WidLimit = 64'(SERDES_BITS) << COARSE_WIDTH_BITS;

    logic [1:0]  in_cmd;
    logic [31:0] in_idx;
    logic [31:0] in_val;
    logic        val_ok;
    logic        item_ok;

    logic [DlyW-1:0] r_delay [NUM_OUTPUTS];
    logic [WidW-1:0] r_width [NUM_OUTPUTS];
    logic [1:0]      r_mode  [NUM_OUTPUTS];
    logic [IdxW-1:0] r_idx;

    logic [DlyW-1:0] rd_d;
    logic [WidW-1:0] rd_w;
    logic [1:0]      rd_m;

    logic            busy_d;
    logic            busy_w;
    logic [DlyW-1:0] quot_d;
    logic [WidW-1:0] quot_w;
    logic [SerW-1:0] rem_d;
    logic [SerW-1:0] rem_w;

    logic [31:0] r_word_sel;
    logic [31:0] r_word_dly;
    logic [31:0] r_word_wid;
    logic [31:0] r_word_mode;

    logic [SerW-1:0]        zeros;
    logic [SerW:0]          lead;
    logic                   short_w;
    logic [SerW:0]          tsum;
    logic                   wrap;
    logic [SerW-1:0]        rm;
    logic [WidW-1:0]        cw;
    logic [31:0]            first_short;
    logic [SERDES_BITS-1:0] first_long;
    logic [SERDES_BITS-1:0] first;
    logic [31:0]            lastp;
    logic [63:0]            cd_shift;
    logic [63:0]            cw_shift;

    // Input word: cmd, then output_index, then value.
    always_comb begin
        in_cmd = i_s_tdata[1:0];
        in_idx = i_s_tdata[33:2];
        in_val = i_s_tdata[65:34];
    end

    always_comb begin
        unique case (in_cmd)
            CMD_MODE:  val_ok = (in_val[31:2] == 30'd0);
            CMD_DELAY: val_ok = !in_val[31] && ({32'd0, in_val} < DlyLimit);
            CMD_WIDTH: val_ok = !in_val[31] && ({32'd0, in_val} < WidLimit);
            default:   val_ok = 1'b0;
        endcase
        // A negative index has bit 31 set and fails the unsigned compare.
        item_ok = val_ok && (in_idx < 32'(NUM_OUTPUTS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_OUTPUTS; i++) begin
                r_delay[i] <= '0;
                r_width[i] <= '0;
                r_mode[i]  <= '0;
            end
        end else if (i_ctl.accept && item_ok) begin
            unique case (in_cmd)
                CMD_MODE:  r_mode[in_idx[IdxW-1:0]]  <= in_val[1:0];
                CMD_DELAY: r_delay[in_idx[IdxW-1:0]] <= in_val[DlyW-1:0];
                CMD_WIDTH: r_width[in_idx[IdxW-1:0]] <= in_val[WidW-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && item_ok) begin
            r_idx <= in_idx[IdxW-1:0];
        end
    end

    always_comb begin
        rd_d = r_delay[r_idx];
        rd_w = r_width[r_idx];
        rd_m = r_mode[r_idx];
    end

    pdws_div #(
        .NUM_W   (DlyW),
        .DIVISOR (SERDES_BITS)
    ) u_div_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.start),
        .i_num   (rd_d),
        .o_busy  (busy_d),
        .o_quot  (quot_d),
        .o_rem   (rem_d)
    );

    pdws_div #(
        .NUM_W   (WidW),
        .DIVISOR (SERDES_BITS)
    ) u_div_wid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.start),
        .i_num   (rd_w),
        .o_busy  (busy_w),
        .o_quot  (quot_w),
        .o_rem   (rem_w)
    );

    // The remainder after the leading partial word is found from the width's own
    // quotient and remainder: r = w - (S - z) = (qw - 1) * S + (rw + z).
    always_comb begin
        zeros       = (rd_m == MODE_PAT) ? '0 : rem_d;
        lead        = (SerW + 1)'(SERDES_BITS) - {1'b0, zeros};
        short_w     = (32'(rd_w) <= 32'(lead));
        tsum        = {1'b0, rem_w} + {1'b0, zeros};
        wrap        = (tsum >= (SerW + 1)'(SERDES_BITS));
        rm          = wrap ? SerW'(tsum - (SerW + 1)'(SERDES_BITS)) : tsum[SerW-1:0];
        cw          = wrap ? quot_w : quot_w - WidW'(1);
        first_short = ((32'd1 << rd_w) - 32'd1) << zeros;
        first_long  = {SERDES_BITS{1'b1}} << zeros;
        first       = short_w ? first_short[SERDES_BITS-1:0] : first_long;
        lastp       = short_w ? 32'd0 : ((32'd1 << rm) - 32'd1);
        cd_shift    = 64'(quot_d) << SERDES_BITS;
        cw_shift    = short_w ? 64'd0 : (64'(cw) << SERDES_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            r_word_sel  <= 32'd1 << r_idx;
            r_word_dly  <= OP_DELAY | cd_shift[31:0] | 32'(first);
            r_word_wid  <= OP_WIDTH | cw_shift[31:0] | lastp;
            r_word_mode <= OP_MODE | {30'd0, rd_m};
        end
    end

    always_comb begin
        unique case (i_ctl.word)
            WORD_SEL:  o_m_tdata = r_word_sel;
            WORD_DLY:  o_m_tdata = r_word_dly;
            WORD_WID:  o_m_tdata = r_word_wid;
            WORD_MODE: o_m_tdata = r_word_mode;
            default:   o_m_tdata = r_word_sel;
        endcase
        o_m_tuser = (i_ctl.word != WORD_SEL);
        o_m_tlast = (i_ctl.word == WORD_MODE);
    end

    assign o_stat.item_ok  = item_ok;
    assign o_stat.div_idle = !(busy_d || busy_w);

endmodule

`default_nettype wire

### rtl/pulse_delay_width_splitter.sv
// Top level of the pulse delay/width splitter: controller, datapath and checks.
// Each request sets the mode, delay or width of one pulse output; a request with a bad
// command, output index or value is dropped in the cycle it is taken and gives no words.
// A good request updates the store and then sends four words: output select (tuser 0),
// delay, width and mode (tuser 1, tlast on the mode word). One request is handled at a
// time. The divides by SERDES_BITS run as a pipelined reciprocal multiplication; once
// both dividers are idle the four words are registered and the select word is offered;
// the four words then leave at one per cycle while the sink is ready, and a new request
// is taken the cycle after the mode word goes out.
`default_nettype none

module pulse_delay_width_splitter
    import pdws_pkg::*;
#(
    parameter int SERDES_BITS       = SERDES_BITS_DEF,
    parameter int NUM_OUTPUTS       = NUM_OUTPUTS_DEF,
    parameter int COARSE_DELAY_BITS = COARSE_DELAY_BITS_DEF,
    parameter int COARSE_WIDTH_BITS = COARSE_WIDTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,  // cmd[1:0], output_index[33:2], value[65:34]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // data[31:0]
    output logic             o_m_axis_tuser,  // target[0]
    output logic             o_m_axis_tlast
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    pdws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_ctl      (ctl),
        .i_stat     (stat)
    );

    pdws_dp #(
        .SERDES_BITS       (SERDES_BITS),
        .NUM_OUTPUTS       (NUM_OUTPUTS),
        .COARSE_DELAY_BITS (COARSE_DELAY_BITS),
        .COARSE_WIDTH_BITS (COARSE_WIDTH_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_axis_tdata),
        .i_ctl     (ctl),
        .o_stat    (stat),
        .o_m_tdata (o_m_axis_tdata),
        .o_m_tuser (o_m_axis_tuser),
        .o_m_tlast (o_m_axis_tlast)
    );

    // No new request is taken while a word is still on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("request taken while output words pending");

    // The mode word closes the run and always targets the configuration register.
    a_last_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser)
        else $error("last word with select target");

    // After the mode word is taken the block goes back to waiting for a request.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=>
            (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("output run did not end after last word");

endmodule

`default_nettype wire

### verif/pulse_delay_width_splitter_tb.sv
// Self-checking testbench for the pulse delay/width splitter stream block.
`timescale 1ns / 100ps

module pulse_delay_width_splitter_tb
    import pdws_pkg::*;
();

    localparam int S        = SERDES_BITS_DEF;
    localparam int NUM      = NUM_OUTPUTS_DEF;
    localparam int CD_BITS  = COARSE_DELAY_BITS_DEF;
    localparam int CW_BITS  = COARSE_WIDTH_BITS_DEF;
    localparam int SETTLE   = 40;
    localparam int HOLD_LEN = 400;
    localparam int LIMIT    = 200_000;
    localparam int MAX_MSGS = 50;

    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [31:0] MODE_FIELD = 32'h3;
    localparam logic [31:0] VALUE_TOP  = (32'd1 << (CD_BITS + 2)) - 1;
    localparam logic        TGT_SELECT = 1'b0;
    localparam logic        TGT_CONFIG = 1'b1;

    typedef struct {
        logic        target;
        logic [31:0] data;
        logic        last;
    } t_reg_word;

    class t_pulse_board;
        logic [25:0] delay_q [NUM];
        logic [25:0] width_q [NUM];
        logic [1:0]  mode_q  [NUM];
        t_reg_word   expected_words[$];
        int          errors;
        int          taken;
        int          dropped;
        int          words_seen;

        function new();
            for (int i = 0; i < NUM; i++) begin
                delay_q[i] = '0;
                width_q[i] = '0;
                mode_q[i]  = '0;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Updates the store for one taken request and, if it is valid, queues the four words it causes.
        function void note_request(logic [1:0] cmd, logic [31:0] idx, logic [31:0] value);
            logic [31:0] d, w, z, cd, lead, r, cw, first, lastp, s_mask;
            longint unsigned quot;
            int unsigned slot;
            bit ok;
            ok = (idx < NUM);
            slot = 32'(idx[4:0]);
            quot = 64'(value) / 64'(S);
            if (ok) begin
                case (cmd)
                    CMD_MODE: begin
                        ok = ((value & MODE_FIELD) == value);
                        if (ok) mode_q[slot] = value[1:0];
                    end
                    CMD_DELAY: begin
                        ok = !value[31] && (quot < (64'd1 << CD_BITS));
                        if (ok) delay_q[slot] = value[25:0];
                    end
                    CMD_WIDTH: begin
                        ok = !value[31] && (quot < (64'd1 << CW_BITS));
                        if (ok) width_q[slot] = value[25:0];
                    end
                    default: ok = 0;
                endcase
            end
            if (!ok) begin
                dropped++;
                return;
            end
            taken++;
            s_mask = (32'd1 << S) - 1;
            d = 32'(delay_q[slot]);
            w = 32'(width_q[slot]);
            // Pattern mode snaps the delay to a whole serializer word.
            if (mode_q[slot] == MODE_PAT) d = d - (d % S);
            z    = d % S;
            cd   = d / S;
            lead = S - z;
            if (w <= lead) begin
                cw    = 0;
                first = ((32'd1 << w) - 1) << z;
                lastp = 0;
            end else begin
                r     = w - lead;
                cw    = r / S;
                first = (s_mask << z) & s_mask;
                lastp = (32'd1 << (r % S)) - 1;
            end
            expected_words.push_back('{TGT_SELECT, 32'd1 << slot, 1'b0});
            expected_words.push_back('{TGT_CONFIG, OP_DELAY | (cd << S) | first, 1'b0});
            expected_words.push_back('{TGT_CONFIG, OP_WIDTH | (cw << S) | lastp, 1'b0});
            expected_words.push_back('{TGT_CONFIG, OP_MODE | {30'd0, mode_q[slot]}, 1'b1});
        endfunction

        function void check_word(logic target, logic [31:0] data, logic last);
            t_reg_word exp_w;
            words_seen++;
            if (expected_words.size() == 0) begin
                if (errors < MAX_MSGS) $error("unexpected word: data %h target %0d", data, target);
                errors++;
                return;
            end
            exp_w = expected_words.pop_front();
            if (target !== exp_w.target) begin
                if (errors < MAX_MSGS)
                    $error("target: expected %0d, actual %0d", exp_w.target, target);
                errors++;
            end
            if (data !== exp_w.data) begin
                if (errors < MAX_MSGS)
                    $error("data: expected %h, actual %h", exp_w.data, data);
                errors++;
            end
            if (last !== exp_w.last) begin
                if (errors < MAX_MSGS)
                    $error("last: expected %0d, actual %0d", exp_w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;

    t_pulse_board board = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    bit rx_hold_req = 0;
    int cycle_count = 0;

    pulse_delay_width_splitter i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // cmd[1:0], output_index[33:2], value[65:34]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // data[31:0]
        .o_m_axis_tuser  (o_m_axis_tuser),   // target[0]
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The sink either stalls at random or sits out a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = HOLD_LEN;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_word(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
    end

    task automatic send_request(logic [1:0] cmd, logic [31:0] idx, logic [31:0] value);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, value, idx, cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_request(cmd, idx, value);
    endtask

    task automatic drain_words();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic directed_requests();
        send_request(CMD_UNUSED, 32'd0, 32'd5);
        send_request(CMD_MODE, 32'hFFFF_FFFF, 32'd0);
        send_request(CMD_MODE, NUM, 32'd1);
        send_request(CMD_DELAY, 32'h8000_0000, 32'd0);
        send_request(CMD_MODE, NUM - 1, 32'd3);
        send_request(CMD_MODE, 32'd0, 32'd4);
        send_request(CMD_MODE, 32'd0, 32'hFFFF_FFFF);
        send_request(CMD_DELAY, 32'd0, 32'd0);
        send_request(CMD_WIDTH, 32'd0, 32'd0);
        send_request(CMD_WIDTH, 32'd0, 32'd3);
        // Delay with leading zeros, so the width spills past the first word.
        send_request(CMD_DELAY, 32'd0, 32'd6);
        send_request(CMD_MODE, 32'd0, 32'(MODE_PAT));
        send_request(CMD_DELAY, 32'd1, VALUE_TOP);
        send_request(CMD_DELAY, 32'd1, VALUE_TOP + 1);
        send_request(CMD_DELAY, 32'd1, 32'hFFFF_FFFF);
        send_request(CMD_WIDTH, 32'd1, VALUE_TOP);
        send_request(CMD_WIDTH, 32'd1, VALUE_TOP + 1);
        send_request(CMD_WIDTH, 32'd1, 32'h8000_0005);
        send_request(CMD_MODE, 32'd1, 32'(MODE_PAT));
        send_request(CMD_MODE, 32'd1, 32'd1);
        send_request(CMD_WIDTH, 32'd2, S);
        send_request(CMD_WIDTH, 32'd2, S + 1);
        send_request(CMD_UNUSED, NUM - 1, 32'h7FFF_FFFF);
        send_request(CMD_DELAY, 32'd3, 32'h7FFF_FFFF);
        send_request(CMD_MODE, NUM - 1, 32'd0);
    endtask

    // Mostly well-formed requests with random content, the rest noise, much of which is dropped.
    task automatic random_requests(int count);
        int          goal;
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] idx;
        logic [31:0] value;
        goal = board.taken + count;
        while (board.taken < goal) begin
            if ($urandom_range(99) < 80) begin
                cmd = 2'($urandom_range(2));
                idx = $urandom_range(NUM - 1);
                pick = $urandom_range(99);
                if (cmd == CMD_MODE)  value = $urandom_range(3);
                else if (pick < 50)   value = $urandom_range(40);
                else if (pick < 85)   value = $urandom_range(VALUE_TOP);
                else                  value = $urandom_range(VALUE_TOP, VALUE_TOP - 8);
            end else begin
                cmd   = 2'($urandom_range(3));
                idx   = $urandom_range(1) ? $urandom : $urandom_range(NUM - 1);
                value = $urandom_range(1) ? $urandom : $urandom_range(VALUE_TOP + 16, VALUE_TOP);
            end
            send_request(cmd, idx, value);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct  = 15;
        rx_stall_pct = 68;
        directed_requests();
        random_requests(40);
        drain_words();

        tx_idle_pct  = 68;
        rx_stall_pct = 15;
        random_requests(40);
        drain_words();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1;
        random_requests(40);
        drain_words();

        $display("Covered %0d accepted and %0d dropped requests, %0d output words checked,",
                 board.taken, board.dropped, board.words_seen);
        $display("under sender idling, sink stalls, a long sink hold-off and idle-free traffic.");
        if (board.errors == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### pulse_delay_width_splitter.f
rtl/pdws_pkg.sv
rtl/pdws_div.sv
rtl/pdws_ctrl.sv
rtl/pdws_dp.sv
rtl/pulse_delay_width_splitter.sv
verif/pulse_delay_width_splitter_tb.sv
